@@ rtl/i2cm_pkg.sv @@
// shared types and constants of the i2c master byte engine
package i2cm_pkg;

    // command codes
    typedef enum logic [1:0] {
        K_START = 2'd0,
        K_STOP  = 2'd1,
        K_WRITE = 2'd2,
        K_READ  = 2'd3
    } t_kind;

    // bit positions in the pin level pair
    localparam int PIN_SCL = 0;
    localparam int PIN_SDA = 1;

    localparam int          DELAY_COUNTER_BITS_DEF = 16;
    localparam logic [15:0] PHASE_TICKS_RESET      = 16'd5;

    // register indexes of the configuration port
    localparam logic REG_PHASE_TICKS = 1'b0;

    // one result beat
    typedef struct packed {
        logic       ack_level;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_out;
        logic       scl_out;
    } t_result;

endpackage

@@ rtl/i2c_master_byte_engine.sv @@
// top level of the i2c master byte engine: stream ports, register port, output skid
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      one bus tick: sampled sda, optional command
//  m_axis    out  m_axis_tvalid/tready      pin levels and status for that tick
//  apb       in   psel/penable/pwrite       phase_ticks at byte address 0
//
// one input beat per cycle while s_axis_tready is high, one result beat per input beat;
// the sequencer state closes its loop combinationally inside i2cm_core, so throughput is
// one beat per clock while m_axis does not stall, and results are registered at acceptance
// reset (synchronous, active low) leaves both pins released and the engine idle
// a stall on m_axis fills the skid register, then s_axis_tready drops until it drains
module i2c_master_byte_engine #(
    parameter int DELAY_COUNTER_BITS = i2cm_pkg::DELAY_COUNTER_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [0] sda_in, [8:1] write_data, [9] send_ack
    input  logic [2:0]  s_axis_tuser,   // [0] cmd_valid, [2:1] kind
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] scl_out, [1] sda_out, [2] busy_res,
                                        // [3] done_res, [11:4] read_data, [12] ack_level
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import i2cm_pkg::*;

    logic [15:0] r_phase_ticks;
    logic        r_out_valid;
    logic        r_skid_valid;
    t_result     r_out_data;
    t_result     r_skid_data;
    t_result     w_result;
    logic        w_accept;
    logic        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // register read-back, word index is paddr[2]
    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_PHASE_TICKS) prdata = {16'd0, r_phase_ticks};
    end

    // input is taken whenever the skid register is free
    assign s_axis_tready = !r_skid_valid;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    i2cm_core #(
        .DELAY_COUNTER_BITS(DELAY_COUNTER_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_accept),
        .i_phase_ticks(r_phase_ticks),
        .i_sda_in     (s_axis_tdata[0]),
        .i_cmd_valid  (s_axis_tuser[0]),
        .i_kind       (s_axis_tuser[2:1]),
        .i_write_data (s_axis_tdata[8:1]),
        .i_send_ack   (s_axis_tdata[9]),
        .o_result     (w_result)
    );

    // control: config register and output/skid occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RESET;
            r_out_valid   <= 1'b0;
            r_skid_valid  <= 1'b0;
        end else begin
            if (w_cfg_wr && paddr[2] == REG_PHASE_TICKS) r_phase_ticks <= pwdata[15:0];
            if (w_accept) begin
                // stalled output with a beat still waiting goes to the skid
                if (r_out_valid && !m_axis_tready) r_skid_valid <= 1'b1;
                else r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                if (r_skid_valid) r_skid_valid <= 1'b0;
                else r_out_valid <= 1'b0;
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (r_out_valid && !m_axis_tready) r_skid_data <= w_result;
            else r_out_data <= w_result;
        end else if (r_out_valid && m_axis_tready && r_skid_valid) begin
            r_out_data <= r_skid_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out_data};

endmodule

@@ rtl/i2cm_core.sv @@
// bus sequencer state and the per-tick step logic of the i2c master
module i2cm_core #(
    parameter int DELAY_COUNTER_BITS = i2cm_pkg::DELAY_COUNTER_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [15:0]       i_phase_ticks,
    input  logic              i_sda_in,
    input  logic              i_cmd_valid,
    input  logic [1:0]        i_kind,
    input  logic [7:0]        i_write_data,
    input  logic              i_send_ack,
    output i2cm_pkg::t_result o_result
);
    import i2cm_pkg::*;

    localparam int CMP_W = ((DELAY_COUNTER_BITS > 16) ? DELAY_COUNTER_BITS : 16) + 1;

    logic [1:0]                    r_pins, n_pins;
    logic                          r_busy, n_busy;
    t_kind                         r_kind, n_kind;
    logic [7:0]                    r_shift, n_shift;
    logic [3:0]                    r_bc, n_bc;
    logic [1:0]                    r_ps, n_ps;
    logic [DELAY_COUNTER_BITS-1:0] r_dc, n_dc;
    logic                          r_ack, n_ack;
    logic                          r_ack_send, n_ack_send;
    logic [7:0]                    r_read, n_read;

    logic [CMP_W-1:0] w_pt, w_cap, w_hold, w_dc_inc;
    logic [1:0]       w_pins_now;
    logic             w_busy_now, w_done_now, w_slot_end, w_fin;

    // pin change made on the first tick of a slot
    function automatic logic [1:0] enter_slot(input t_kind kind, input logic [1:0] ps,
                                              input logic [3:0] bc, input logic [7:0] shift,
                                              input logic acks, input logic [1:0] pins);
        logic [1:0] p;
        p = pins;
        case (kind)
            K_START: begin
                case (ps)
                    2'd0:    p[PIN_SDA] = 1'b1;
                    2'd1:    p[PIN_SCL] = 1'b1;
                    2'd2:    p[PIN_SDA] = 1'b0;
                    default: p[PIN_SCL] = 1'b0;
                endcase
            end
            K_STOP: begin
                case (ps)
                    2'd0:    p[PIN_SDA] = 1'b0;
                    2'd1:    p[PIN_SCL] = 1'b1;
                    default: p[PIN_SDA] = 1'b1;
                endcase
            end
            K_WRITE: begin
                if (ps == 2'd0) begin
                    p[PIN_SDA] = bc[3] ? 1'b1 : shift[~bc[2:0]];
                end else if (ps == 2'd1) begin
                    p[PIN_SCL] = 1'b1;
                end else begin
                    p[PIN_SCL] = 1'b0;
                end
            end
            default: begin
                if (ps == 2'd2) begin
                    p[PIN_SDA] = 1'b1;
                end else if (ps == 2'd0) begin
                    p[PIN_SCL] = 1'b1;
                end else begin
                    p[PIN_SCL] = 1'b0;
                    if (bc == 4'd7) p[PIN_SDA] = ~acks;
                end
            end
        endcase
        return p;
    endfunction

    // slot length: zero acts as one, capped at the counter range
    assign w_pt   = (i_phase_ticks == 16'd0) ? CMP_W'(1) : CMP_W'(i_phase_ticks);
    assign w_cap  = CMP_W'(1) << DELAY_COUNTER_BITS;
    assign w_hold = (w_pt > w_cap) ? w_cap : w_pt;

    always_comb begin
        n_pins     = r_pins;
        n_busy     = r_busy;
        n_kind     = r_kind;
        n_shift    = r_shift;
        n_bc       = r_bc;
        n_ps       = r_ps;
        n_dc       = r_dc;
        n_ack      = r_ack;
        n_ack_send = r_ack_send;
        n_read     = r_read;
        w_busy_now = 1'b0;
        w_done_now = 1'b0;
        w_fin      = 1'b0;

        // launch a command when idle
        if (!r_busy && i_cmd_valid) begin
            n_busy     = 1'b1;
            n_kind     = t_kind'(i_kind);
            n_ack_send = i_send_ack;
            n_shift    = (t_kind'(i_kind) == K_WRITE) ? i_write_data : 8'd0;
            n_bc       = 4'd0;
            n_ps       = (t_kind'(i_kind) == K_READ) ? 2'd2 : 2'd0;
            n_dc       = '0;
            n_pins     = enter_slot(n_kind, n_ps, n_bc, n_shift, n_ack_send, n_pins);
        end

        w_pins_now = n_pins;
        w_dc_inc   = CMP_W'(n_dc) + CMP_W'(1);
        w_slot_end = (w_dc_inc >= w_hold);

        if (n_busy) begin
            w_busy_now = 1'b1;
            if (w_slot_end) begin
                n_dc = '0;
                case (n_kind)
                    K_START: begin
                        if (n_ps == 2'd3) w_fin = 1'b1;
                        else n_ps = n_ps + 2'd1;
                    end
                    K_STOP: begin
                        if (n_ps >= 2'd2) w_fin = 1'b1;
                        else n_ps = n_ps + 2'd1;
                    end
                    K_WRITE: begin
                        // ack sampled at the end of the high phase after the last bit
                        if (n_ps == 2'd1 && n_bc[3]) n_ack = i_sda_in;
                        if (n_ps < 2'd2) begin
                            n_ps = n_ps + 2'd1;
                        end else if (n_bc[3]) begin
                            w_fin = 1'b1;
                        end else begin
                            n_bc = n_bc + 4'd1;
                            n_ps = 2'd0;
                        end
                    end
                    default: begin
                        if (n_ps == 2'd2) begin
                            n_ps = 2'd0;
                        end else if (n_ps == 2'd0) begin
                            if (!n_bc[3]) n_shift = {n_shift[6:0], i_sda_in};
                            n_ps = 2'd1;
                        end else if (n_bc[3]) begin
                            n_read          = n_shift;
                            n_pins[PIN_SDA] = 1'b1;
                            w_fin           = 1'b1;
                        end else begin
                            n_bc = n_bc + 4'd1;
                            n_ps = 2'd0;
                        end
                    end
                endcase
                if (w_fin) begin
                    n_busy     = 1'b0;
                    w_done_now = 1'b1;
                end else begin
                    n_pins = enter_slot(n_kind, n_ps, n_bc, n_shift, n_ack_send, n_pins);
                end
            end else begin
                n_dc = n_dc + DELAY_COUNTER_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pins     <= 2'b11;
            r_busy     <= 1'b0;
            r_kind     <= K_START;
            r_shift    <= 8'd0;
            r_bc       <= 4'd0;
            r_ps       <= 2'd0;
            r_dc       <= '0;
            r_ack      <= 1'b0;
            r_ack_send <= 1'b0;
            r_read     <= 8'd0;
        end else if (i_step) begin
            r_pins     <= n_pins;
            r_busy     <= n_busy;
            r_kind     <= n_kind;
            r_shift    <= n_shift;
            r_bc       <= n_bc;
            r_ps       <= n_ps;
            r_dc       <= n_dc;
            r_ack      <= n_ack;
            r_ack_send <= n_ack_send;
            r_read     <= n_read;
        end
    end

    assign o_result.scl_out   = w_pins_now[PIN_SCL];
    assign o_result.sda_out   = w_pins_now[PIN_SDA];
    assign o_result.busy_res  = w_busy_now;
    assign o_result.done_res  = w_done_now;
    assign o_result.read_data = n_read;
    assign o_result.ack_level = n_ack;

endmodule

@@ bench/tb_top.sv @@
// testbench for the i2c master byte engine: predicted pin levels and status checked beat by beat
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    // register addresses on the apb port
    localparam logic [2:0] ADDR_PHASE = {REG_PHASE_TICKS, 2'b00};
    localparam logic [2:0] ADDR_SPARE = 3'd4;   // index 1, nothing mapped there

    localparam int STALL_PCT = 23;

    // one bus tick as presented on the input stream
    typedef struct {
        logic       sda;
        logic       cmd_valid;
        t_kind      kind;
        logic [7:0] wdata;
        logic       sack;
    } t_tick;

    // predicts the pin levels and status of every tick and checks the result stream
    class pin_board;
        logic [15:0]     hold_ticks;
        logic [1:0]      pins;
        bit              run;
        t_kind           act;
        logic [7:0]      shreg;
        logic [3:0]      bitn;
        logic [1:0]      slot;
        longint unsigned dly;
        logic            ack_seen;
        logic            ack_tx;
        logic [7:0]      rd_byte;
        t_result         pin_status_q[$];
        int unsigned     bad;
        int unsigned     checked;
        int unsigned     ignored;
        int unsigned     begun;
        int unsigned     started[4];

        function new();
            hold_ticks = PHASE_TICKS_RESET;
            pins       = 2'b11;
            run        = 0;
            act        = K_START;
            shreg      = '0;
            bitn       = '0;
            slot       = '0;
            dly        = 0;
            ack_seen   = 0;
            ack_tx     = 0;
            rd_byte    = '0;
            bad        = 0;
            checked    = 0;
            ignored    = 0;
            begun      = 0;
            foreach (started[i]) started[i] = 0;
        endfunction

        // pin change on the first tick of a slot
        function void enter_slot();
            case (act)
                K_START: begin
                    case (slot)
                        2'd0:    pins[PIN_SDA] = 1'b1;
                        2'd1:    pins[PIN_SCL] = 1'b1;
                        2'd2:    pins[PIN_SDA] = 1'b0;
                        default: pins[PIN_SCL] = 1'b0;
                    endcase
                end
                K_STOP: begin
                    case (slot)
                        2'd0:    pins[PIN_SDA] = 1'b0;
                        2'd1:    pins[PIN_SCL] = 1'b1;
                        default: pins[PIN_SDA] = 1'b1;
                    endcase
                end
                K_WRITE: begin
                    if (slot == 2'd0)
                        pins[PIN_SDA] = (bitn < 8) ? shreg[7 - bitn] : 1'b1;
                    else
                        pins[PIN_SCL] = (slot == 2'd1);
                end
                default: begin
                    if (slot == 2'd2) begin
                        pins[PIN_SDA] = 1'b1;
                    end else if (slot == 2'd0) begin
                        pins[PIN_SCL] = 1'b1;
                    end else begin
                        pins[PIN_SCL] = 1'b0;
                        // ack level goes out while scl is low after the last data bit
                        if (bitn == 7) pins[PIN_SDA] = ~ack_tx;
                    end
                end
            endcase
        endfunction

        // end of a slot: sample where due, advance, tell whether the command is over
        function bit leave_slot(logic sda);
            case (act)
                K_START: begin
                    if (slot == 2'd3) return 1;
                    slot = slot + 2'd1;
                end
                K_STOP: begin
                    if (slot >= 2'd2) return 1;
                    slot = slot + 2'd1;
                end
                K_WRITE: begin
                    if (slot == 2'd1 && bitn >= 8) ack_seen = sda;
                    if (slot < 2'd2) begin
                        slot = slot + 2'd1;
                        return 0;
                    end
                    if (bitn >= 8) return 1;
                    bitn = bitn + 4'd1;
                    slot = 2'd0;
                end
                default: begin
                    if (slot == 2'd2) begin
                        slot = 2'd0;
                        return 0;
                    end
                    if (slot == 2'd0) begin
                        if (bitn < 8) shreg = {shreg[6:0], sda};
                        slot = 2'd1;
                        return 0;
                    end
                    if (bitn >= 8) begin
                        rd_byte = shreg;
                        pins[PIN_SDA] = 1'b1;   // released, visible from the next tick
                        return 1;
                    end
                    bitn = bitn + 4'd1;
                    slot = 2'd0;
                end
            endcase
            return 0;
        endfunction

        // one accepted input beat: advance the sequencer, queue the expected result
        function void note_tick(t_tick t);
            t_result         r;
            longint unsigned hold;
            if (t.cmd_valid) begin
                if (run) begin
                    ignored++;
                end else begin
                    run    = 1;
                    act    = t.kind;
                    ack_tx = t.sack;
                    shreg  = (t.kind == K_WRITE) ? t.wdata : 8'd0;
                    bitn   = '0;
                    slot   = (t.kind == K_READ) ? 2'd2 : 2'd0;
                    dly    = 0;
                    begun++;
                    started[t.kind]++;
                    enter_slot();
                end
            end
            r = '0;
            r.scl_out = pins[PIN_SCL];
            r.sda_out = pins[PIN_SDA];
            if (run) begin
                r.busy_res = 1'b1;
                // a zero hold counts as one tick, and the counter width caps long holds
                hold = (hold_ticks == 0) ? 1 : hold_ticks;
                if (hold > (64'd1 << DELAY_COUNTER_BITS_DEF)) begin
                    hold = 64'd1 << DELAY_COUNTER_BITS_DEF;
                end
                if (dly + 1 >= hold) begin
                    dly = 0;
                    if (leave_slot(t.sda)) begin
                        run = 0;
                        r.done_res = 1'b1;
                    end else begin
                        enter_slot();
                    end
                end else begin
                    dly++;
                end
            end
            r.read_data = rd_byte;
            r.ack_level = ack_seen;
            pin_status_q.push_back(r);
        endfunction

        // one accepted result beat against the oldest expectation
        function void check_beat(logic [15:0] data);
            t_result got;
            t_result want;
            got = data[12:0];
            if (pin_status_q.size() == 0) begin
                bad++;
                if (bad <= 10) $display("unexpected result beat %h, nothing pending", data);
                return;
            end
            want = pin_status_q.pop_front();
            checked++;
            if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
                got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
                got.read_data !== want.read_data || got.ack_level !== want.ack_level) begin
                bad++;
                if (bad <= 10) begin
                    $display("beat %0d: want scl %b sda %b busy %b done %b rd %h ack %b",
                             checked, want.scl_out, want.sda_out, want.busy_res,
                             want.done_res, want.read_data, want.ack_level);
                    $display("beat %0d: got  scl %b sda %b busy %b done %b rd %h ack %b",
                             checked, got.scl_out, got.sda_out, got.busy_res,
                             got.done_res, got.read_data, got.ack_level);
                end
            end
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;    // [0] sda_in, [8:1] write_data, [9] send_ack
    logic [2:0]  s_axis_tuser  = '0;    // [0] cmd_valid, [2:1] kind
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    wire  [15:0] m_axis_tdata;          // [0] scl_out, [1] sda_out, [2] busy_res,
                                        // [3] done_res, [11:4] read_data, [12] ack_level
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    wire  [31:0] prdata;
    wire         pready;

    pin_board    sb;
    bit          calm      = 0;     // no idling on either side while set
    int unsigned reg_errs  = 0;
    int unsigned cfg_writes = 0;

    i2c_master_byte_engine i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // result side: check every accepted beat, then pick the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= STALL_PCT);
    end

    // tick with no command, every other field random
    function automatic t_tick quiet_tick();
        t_tick t;
        t.sda       = 1'($urandom);
        t.cmd_valid = 1'b0;
        t.kind      = t_kind'($urandom_range(3));
        t.wdata     = 8'($urandom);
        t.sack      = 1'($urandom);
        return t;
    endfunction

    // present one beat after a random gap and hold it until accepted
    task automatic send_tick(t_tick t);
        while (!calm && $urandom_range(99) < STALL_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, t.sack, t.wdata, t.sda};
        s_axis_tuser  <= {t.kind, t.cmd_valid};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        sb.note_tick(t);
    endtask

    // one command from an idle engine; noise_pct of the busy ticks carry a stray command
    task automatic run_cmd(t_kind k, logic [7:0] d, logic ack, int noise_pct);
        t_tick t;
        repeat ($urandom_range(0, 2)) send_tick(quiet_tick());
        t           = quiet_tick();
        t.cmd_valid = 1'b1;
        t.kind      = k;
        t.wdata     = d;
        t.sack      = ack;
        send_tick(t);
        // stray commands here must be ignored, the done tick included
        while (sb.run) begin
            t = quiet_tick();
            if ($urandom_range(99) < noise_pct) t.cmd_valid = 1'b1;
            send_tick(t);
        end
    endtask

    // start, a few byte operations with an occasional repeated start, stop
    task automatic run_transfer(int noise_pct);
        int ops;
        ops = $urandom_range(1, 4);
        run_cmd(K_START, 8'($urandom), 1'($urandom), noise_pct);
        repeat (ops) begin
            case ($urandom_range(9))
                0:          run_cmd(K_START, 8'($urandom), 1'($urandom), noise_pct);
                1, 2, 3, 4: run_cmd(K_WRITE, 8'($urandom), 1'($urandom), noise_pct);
                default:    run_cmd(K_READ, 8'($urandom), 1'($urandom), noise_pct);
            endcase
        end
        run_cmd(K_STOP, 8'($urandom), 1'($urandom), noise_pct);
    endtask

    // setup then access phase; the bus goes idle after every transfer
    task automatic apb_access(bit wr, logic [2:0] addr, logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic read_hold_back(logic [15:0] want);
        logic [31:0] rd;
        apb_access(1'b0, ADDR_PHASE, 32'd0, rd);
        if (rd[15:0] !== want) begin
            reg_errs++;
            if (reg_errs <= 10) $display("phase_ticks reads %h, want %h", rd[15:0], want);
        end
    endtask

    // new hold only once the stream has drained and the engine is idle
    task automatic set_hold(logic [15:0] v);
        logic [31:0] w;
        logic [31:0] rd;
        s_axis_tvalid <= 1'b0;
        while (sb.pin_status_q.size() != 0) @(posedge i_clk);
        w       = $urandom();
        w[15:0] = v;            // upper bits are junk the register must drop
        apb_access(1'b1, ADDR_PHASE, w, rd);
        sb.hold_ticks = v;
        cfg_writes++;
        read_hold_back(v);
    endtask

    initial begin
        int          r;
        logic [15:0] hv;
        logic [31:0] rd;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset hold on a short start and stop
        read_hold_back(PHASE_TICKS_RESET);
        run_cmd(K_START, 8'h00, 1'b0, 20);
        run_cmd(K_STOP, 8'hFF, 1'b0, 20);

        // zero hold behaves as one tick per slot; both byte extremes, ack and nack on reads
        set_hold(16'd0);
        run_cmd(K_START, 8'h00, 1'b0, 30);
        run_cmd(K_WRITE, 8'h00, 1'b0, 30);
        run_cmd(K_WRITE, 8'hFF, 1'b1, 30);
        run_cmd(K_WRITE, 8'hA5, 1'b1, 30);
        run_cmd(K_READ, 8'hFF, 1'b0, 30);
        run_cmd(K_READ, 8'h5A, 1'b1, 30);
        run_cmd(K_STOP, 8'h00, 1'b1, 30);

        // write to the unmapped index must leave phase_ticks alone
        s_axis_tvalid <= 1'b0;
        while (sb.pin_status_q.size() != 0) @(posedge i_clk);
        apb_access(1'b1, ADDR_SPARE, $urandom(), rd);
        read_hold_back(16'd0);

        set_hold(16'd1);
        run_cmd(K_START, 8'h00, 1'b0, 50);
        run_cmd(K_READ, 8'h00, 1'b0, 50);
        run_cmd(K_STOP, 8'h00, 1'b0, 50);
        run_cmd(K_STOP, 8'h00, 1'b0, 50);
        set_hold(16'd2);
        run_cmd(K_START, 8'h00, 1'b0, 10);
        run_cmd(K_WRITE, 8'h80, 1'b0, 10);
        run_cmd(K_STOP, 8'h00, 1'b0, 10);

        // stretch with both sides at full rate
        calm = 1;
        set_hold(16'd1);
        run_transfer(10);
        calm = 0;

        // random phases: mostly well-formed transfers, some loose command mixes
        while (sb.checked + sb.pin_status_q.size() < 450) begin
            r = $urandom_range(99);
            if (r < 45)      hv = 16'd1;
            else if (r < 75) hv = 16'd2;
            else if (r < 90) hv = 16'd3;
            else             hv = 16'd0;
            set_hold(hv);
            if ($urandom_range(99) < 80)
                run_transfer(10);
            else
                repeat ($urandom_range(1, 3))
                    run_cmd(t_kind'($urandom_range(3)), 8'($urandom), 1'($urandom), 30);
        end

        // drain, then give any stray beat time to show up
        s_axis_tvalid <= 1'b0;
        while (sb.pin_status_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("checked %0d tick beats; commands run: start %0d, stop %0d, write %0d, read %0d",
                 sb.checked, sb.started[K_START], sb.started[K_STOP], sb.started[K_WRITE],
                 sb.started[K_READ]);
        $display("%0d stray commands ignored; %0d hold settings from 0 to 3, each read back",
                 sb.ignored, cfg_writes);
        if (sb.bad == 0 && reg_errs == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #(20_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
